// ----- rtl/mkss_pkg.sv -----
// ----------------------------------------------------------------------------
// mkss_pkg: shared types and constants of the k-mer score scan
// Table geometry, operation and register codes, base mapping and the
// structs that pass between the scan datapath and the table memories.
// ----------------------------------------------------------------------------
`default_nettype none

package mkss_pkg;

  // model geometry
  localparam int MAX_ORDER  = 5;
  localparam int ROWS       = 3;
  localparam int WIN_DEPTH  = MAX_ORDER + 1;
  localparam int INI_AW     = 2 * MAX_ORDER;
  localparam int TRN_AW     = 2 * (MAX_ORDER + 1);
  localparam int INI_SIZE   = 1 << INI_AW;
  localparam int TRN_SIZE   = 1 << TRN_AW;
  localparam int ROW_W      = $clog2(ROWS);

  // window index may exceed the row size when a digit is 4
  localparam int IDX_W      = 13;
  localparam int DIGIT_W    = 3;
  localparam int SEEN_W     = 3;
  localparam int ORDER_W    = 3;

  localparam int SCORE_W    = 32;
  localparam int SUM_W      = 48;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int INI_DIM_W  = 11;
  localparam int TRN_DIM_W  = 13;

  localparam logic [DIGIT_W-1:0] DIGIT_OTHER = 3'd4;

  typedef enum logic [1:0] {
    OP_BASE     = 2'd0,
    OP_LOAD_INI = 2'd1,
    OP_LOAD_TRN = 2'd2,
    OP_UNUSED   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODEL_ORDER    = 2'd0,
    REG_INITIAL_DIM    = 2'd1,
    REG_TRANSITION_DIM = 2'd2,
    REG_NULL_SCORE     = 2'd3
  } cfg_reg_e;

  // table write request
  typedef struct packed {
    logic                en;
    logic                trn;
    logic [ROW_W-1:0]    row;
    logic [TRN_AW-1:0]   addr;
    logic [SCORE_W-1:0]  data;
  } mkss_wr_t;

  // table read request, one address per table, all rows at once
  typedef struct packed {
    logic                en;
    logic [INI_AW-1:0]   ini_addr;
    logic [TRN_AW-1:0]   trn_addr;
  } mkss_rd_t;

  // map an ASCII nucleotide to a digit, either case, U as T
  function automatic logic [DIGIT_W-1:0] map_base(input logic [7:0] c);
    logic [DIGIT_W-1:0] d;
    d = DIGIT_OTHER;
    if (c[7:6] == 2'b01) begin
      case (c[4:0])
        5'h01:   d = 3'd0;
        5'h03:   d = 3'd1;
        5'h07:   d = 3'd2;
        5'h14:   d = 3'd3;
        5'h15:   d = 3'd3;
        default: d = DIGIT_OTHER;
      endcase
    end
    return d;
  endfunction

  // table row read by frame x at a given phase: (3 - x + phase) mod 3
  function automatic logic [ROW_W-1:0] frame_row(input logic [ROW_W-1:0] x,
                                                  input logic [ROW_W-1:0] phase);
    logic [2:0] t;
    t = 3'(phase) + 3'(ROWS) - 3'(x);
    if (t >= 3'(ROWS)) begin
      t = t - 3'(ROWS);
    end
    return t[ROW_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mkss_if.sv -----
// ----------------------------------------------------------------------------
// mkss_if: stream channels of the k-mer score scan
// Input channel carries base and table load words; output channel carries
// the per-base scores and running frame sums.
// ----------------------------------------------------------------------------
`default_nettype none

interface mkss_in_if import mkss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                operation;
  logic [7:0]                base_char;
  logic [1:0]                table_row;
  logic [TRN_AW-1:0]         table_index;
  logic signed [SCORE_W-1:0] table_value;
  logic                      last_base;

  modport source (output valid, operation, base_char, table_row, table_index,
                  table_value, last_base, input ready);
  modport sink   (input valid, operation, base_char, table_row, table_index,
                  table_value, last_base, output ready);
endinterface

interface mkss_out_if import mkss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      initial_valid;
  logic signed [SCORE_W-1:0] initial_score_f0;
  logic signed [SCORE_W-1:0] initial_score_f1;
  logic signed [SCORE_W-1:0] initial_score_f2;
  logic                      transition_valid;
  logic signed [SUM_W-1:0]   running_sum_f0;
  logic signed [SUM_W-1:0]   running_sum_f1;
  logic signed [SUM_W-1:0]   running_sum_f2;
  logic                      final_result;

  modport source (output valid, initial_valid, initial_score_f0, initial_score_f1,
                  initial_score_f2, transition_valid, running_sum_f0,
                  running_sum_f1, running_sum_f2, final_result, input ready);
  modport sink   (input valid, initial_valid, initial_score_f0, initial_score_f1,
                  initial_score_f2, transition_valid, running_sum_f0,
                  running_sum_f1, running_sum_f2, final_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/mkss_tables.sv -----
// ----------------------------------------------------------------------------
// mkss_tables: initial and transition log-probability memories
// One memory per row and table; all rows of both tables are read in
// parallel at one address each, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mkss_tables import mkss_pkg::*; (
  input  logic                              clk_i,
  input  mkss_wr_t                          wr_i,
  input  mkss_rd_t                          rd_i,
  output logic [ROWS-1:0][SCORE_W-1:0]      ini_data_o,
  output logic [ROWS-1:0][SCORE_W-1:0]      trn_data_o
);

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic [SCORE_W-1:0] ini_mem [INI_SIZE];
    logic [SCORE_W-1:0] trn_mem [TRN_SIZE];
    logic [SCORE_W-1:0] ini_rd_q;
    logic [SCORE_W-1:0] trn_rd_q;

    // write one initial word, read the row at the window index
    always_ff @(posedge clk_i) begin
      if (wr_i.en && !wr_i.trn && (wr_i.row == ROW_W'(r))) begin
        ini_mem[wr_i.addr[INI_AW-1:0]] <= wr_i.data;
      end
      if (rd_i.en) begin
        ini_rd_q <= ini_mem[rd_i.ini_addr];
      end
    end

    // write one transition word, read the row at the window index
    always_ff @(posedge clk_i) begin
      if (wr_i.en && wr_i.trn && (wr_i.row == ROW_W'(r))) begin
        trn_mem[wr_i.addr] <= wr_i.data;
      end
      if (rd_i.en) begin
        trn_rd_q <= trn_mem[rd_i.trn_addr];
      end
    end

    assign ini_data_o[r] = ini_rd_q;
    assign trn_data_o[r] = trn_rd_q;
  end

endmodule

`default_nettype wire

// ----- rtl/markov_kmer_score_scan.sv -----
// ----------------------------------------------------------------------------
// markov_kmer_score_scan: codon-frame Markov log-likelihood scan
// Scores a DNA base stream against initial and transition tables, giving
// three initial scores and three saturating running sums per base.
// ----------------------------------------------------------------------------
// The block takes one word per cycle, base or table load, while the result
// register is not held by a stalled output. A base word's result is
// registered in order: the window index is formed as the word is taken and
// addresses six table memories (one per row of each table), whose
// registered read data then feeds the three frame adders into the result
// register. Load words write at most one table entry and give no result.
// Table entries must be loaded before the window can reach them; the
// memories have no reset. Configuration is to be written by the user only
// while no base word is in flight; the block does not enforce it.
`default_nettype none

module markov_kmer_score_scan import mkss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mkss_in_if.sink               in_i,
  mkss_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef struct packed {
    logic             ini_ok;
    logic             ini_hit;
    logic             trn_ok;
    logic             trn_hit;
    logic [ROW_W-1:0] phase;
    logic             last;
  } s1_t;

  // configuration
  logic [ORDER_W-1:0]        order_q;
  logic [INI_DIM_W-1:0]      ini_dim_q;
  logic [TRN_DIM_W-1:0]      trn_dim_q;
  logic signed [SCORE_W-1:0] null_q;

  // stretch state
  logic [WIN_DEPTH-1:0][DIGIT_W-1:0] win_q, win_shift;
  logic [SEEN_W-1:0]                 seen_q, seen_next;
  logic [ROW_W-1:0]                  phase_q, phase_next;

  logic [ORDER_W-1:0] k_eff;
  logic [3:0]         len_ini, len_trn;
  logic [IDX_W-1:0]   ini_idx, trn_idx;
  logic               ini_ok, trn_ok, ini_hit, trn_hit;

  logic     in_fire, base_fire, s1_adv;
  op_e      op;
  mkss_wr_t wr;
  mkss_rd_t rd;

  logic [ROWS-1:0][SCORE_W-1:0] ini_data, trn_data;

  logic s1_v_q;
  s1_t  s1_q;

  // result register and frame accumulators
  logic                                out_v_q;
  logic [ROWS-1:0][SUM_W-1:0]          acc_q, acc_new;
  logic                                o_ini_valid_q, o_trn_valid_q, o_last_q;
  logic [ROWS-1:0][SCORE_W-1:0]        o_score_q, o_score_d;
  logic [ROWS-1:0][SUM_W-1:0]          o_sum_q;

  function automatic logic [IDX_W-1:0] win_index(
      input logic [WIN_DEPTH-1:0][DIGIT_W-1:0] w,
      input logic [3:0] len);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < WIN_DEPTH; j++) begin
      if (4'(j) < len) begin
        idx = idx + (IDX_W'(w[j]) << (2 * j));
      end
    end
    return idx;
  endfunction

  // handshake
  assign op        = op_e'(in_i.operation);
  assign s1_adv    = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || s1_adv;
  assign in_fire   = in_i.valid && in_i.ready;
  assign base_fire = in_fire && (op == OP_BASE);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q   <= 3'd5;
      ini_dim_q <= 11'd1024;
      trn_dim_q <= 13'd4096;
      null_q    <= -32'sd655360;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MODEL_ORDER:    order_q   <= cfg_data_i[ORDER_W-1:0];
        REG_INITIAL_DIM:    ini_dim_q <= cfg_data_i[INI_DIM_W-1:0];
        REG_TRANSITION_DIM: trn_dim_q <= cfg_data_i[TRN_DIM_W-1:0];
        REG_NULL_SCORE:     null_q    <= cfg_data_i[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // shift the new digit in and form both window indices
  always_comb begin
    win_shift[0] = map_base(in_i.base_char);
    for (int j = 1; j < WIN_DEPTH; j++) begin
      win_shift[j] = win_q[j-1];
    end
    seen_next = (seen_q == '1) ? seen_q : seen_q + 1'b1;

    if (order_q == '0) begin
      k_eff = 3'd1;
    end else if (order_q > ORDER_W'(MAX_ORDER)) begin
      k_eff = ORDER_W'(MAX_ORDER);
    end else begin
      k_eff = order_q;
    end
    len_ini = {1'b0, k_eff};
    len_trn = len_ini + 4'd1;

    ini_ok  = {1'b0, seen_next} >= len_ini;
    trn_ok  = {1'b0, seen_next} >= len_trn;
    ini_idx = win_index(win_shift, len_ini);
    trn_idx = win_index(win_shift, len_trn);
    ini_hit = (ini_idx < IDX_W'(ini_dim_q)) && (ini_idx < IDX_W'(INI_SIZE));
    trn_hit = (trn_idx < IDX_W'(trn_dim_q)) && (trn_idx < IDX_W'(TRN_SIZE));

    phase_next = (phase_q == ROW_W'(ROWS - 1)) ? '0 : phase_q + 1'b1;
  end

  // advance the window; drop the stretch after its last base
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      seen_q  <= '0;
      phase_q <= '0;
    end else if (base_fire) begin
      if (in_i.last_base) begin
        win_q   <= '0;
        seen_q  <= '0;
        phase_q <= '0;
      end else begin
        win_q  <= win_shift;
        seen_q <= seen_next;
        if (trn_ok) begin
          phase_q <= phase_next;
        end
      end
    end
  end

  // table write and read requests
  always_comb begin
    wr.en   = in_fire && (in_i.table_row < ROW_W'(ROWS)) &&
              (((op == OP_LOAD_INI) && (in_i.table_index[TRN_AW-1:INI_AW] == '0)) ||
               (op == OP_LOAD_TRN));
    wr.trn  = (op == OP_LOAD_TRN);
    wr.row  = in_i.table_row;
    wr.addr = in_i.table_index;
    wr.data = in_i.table_value;

    rd.en       = base_fire;
    rd.ini_addr = ini_idx[INI_AW-1:0];
    rd.trn_addr = trn_idx[TRN_AW-1:0];
  end

  mkss_tables u_tables (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_i       (rd),
    .ini_data_o (ini_data),
    .trn_data_o (trn_data)
  );

  // hold the lookup flags alongside the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_v_q <= base_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (base_fire) begin
      s1_q.ini_ok  <= ini_ok;
      s1_q.ini_hit <= ini_hit;
      s1_q.trn_ok  <= trn_ok;
      s1_q.trn_hit <= trn_hit;
      s1_q.phase   <= phase_q;
      s1_q.last    <= in_i.last_base;
    end
  end

  // select scores and add into the saturating frame sums
  always_comb begin
    logic [ROW_W-1:0]          r;
    logic signed [SCORE_W-1:0] v;
    logic signed [SUM_W:0]     s;
    for (int x = 0; x < ROWS; x++) begin
      if (!s1_q.ini_ok) begin
        o_score_d[x] = '0;
      end else if (s1_q.ini_hit) begin
        o_score_d[x] = ini_data[x];
      end else begin
        o_score_d[x] = null_q;
      end

      r = frame_row(ROW_W'(x), s1_q.phase);
      v = s1_q.trn_hit ? signed'(trn_data[r]) : null_q;
      s = (SUM_W+1)'(signed'(acc_q[x])) + (SUM_W+1)'(v);
      if (!s1_q.trn_ok) begin
        acc_new[x] = acc_q[x];
      end else if (s[SUM_W] != s[SUM_W-1]) begin
        acc_new[x] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        acc_new[x] = s[SUM_W-1:0];
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      acc_q   <= '0;
    end else if (s1_adv) begin
      out_v_q <= s1_v_q;
      if (s1_v_q) begin
        acc_q <= s1_q.last ? '0 : acc_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_v_q) begin
      o_ini_valid_q <= s1_q.ini_ok;
      o_trn_valid_q <= s1_q.trn_ok;
      o_last_q      <= s1_q.last;
      o_score_q     <= o_score_d;
      o_sum_q       <= acc_new;
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.initial_valid    = o_ini_valid_q;
  assign out_o.initial_score_f0 = o_score_q[0];
  assign out_o.initial_score_f1 = o_score_q[1];
  assign out_o.initial_score_f2 = o_score_q[2];
  assign out_o.transition_valid = o_trn_valid_q;
  assign out_o.running_sum_f0   = o_sum_q[0];
  assign out_o.running_sum_f1   = o_sum_q[1];
  assign out_o.running_sum_f2   = o_sum_q[2];
  assign out_o.final_result     = o_last_q;

endmodule

`default_nettype wire
